### hw/rtl/dc_motor_position_pid_top_macros.svh
// Assertion macros for the motor position controller.
`ifndef DC_MOTOR_POSITION_PID_TOP_MACROS_SVH
`define DC_MOTOR_POSITION_PID_TOP_MACROS_SVH
`ifndef ASSERT_OFF
`define DMP_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define DMP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define DMP_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define DMP_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

### hw/rtl/dmp_pkg.sv
package dmp_pkg;

    localparam int CountsPerTurn = 480;
    localparam int Half = CountsPerTurn / 2;
    localparam int DeadZone = CountsPerTurn / 20;
    localparam int PwmTop = 8000;
    localparam int IntegLim = 48 * 100;

    localparam int PosW = 10;
    localparam int DutyW = 13;
    localparam int GapW = 9;
    localparam int GainW = 15;
    localparam int CfgIdxW = 2;
    localparam int CfgDataW = 16;

    // Accumulator width for the control word and the serial products.
    localparam int AccW = 48;

    localparam logic [CfgIdxW-1:0] RegPropGain = 2'd0;
    localparam logic [CfgIdxW-1:0] RegIntegGain = 2'd1;
    localparam logic [CfgIdxW-1:0] RegDerivGain = 2'd2;
    localparam logic [CfgIdxW-1:0] RegLoopEnable = 2'd3;

    localparam logic [1:0] ModePulse = 2'd0;
    localparam logic [1:0] ModeTick = 2'd1;
    localparam logic [1:0] ModeSample = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_TGT_MUL,
        ST_TGT_DIV,
        ST_PROP,
        ST_INTEG,
        ST_INTEG_DIV,
        ST_DERIV,
        ST_DERIV_DIV,
        ST_SCALE,
        ST_SCALE_DIV,
        ST_OUT
    } state_t;

endpackage

### hw/rtl/dc_motor_position_pid_top.sv
// Position controller for a DC motor with a quadrature encoder.
// Input items arrive on the s_axis channel: tuser carries the mode (0 encoder
// pulse, 1 control tick, 2 target converter sample), tdata carries direction in
// bit 0 and the 10-bit sample in bits 10:1. Mode 3 is dropped without a result.
// Every control tick yields one beat on the m_axis channel: tdata holds duty_a
// [12:0], duty_b [25:13], gap [34:26] and bias_on [35], zero filled to 40 bits.
// Gains and the loop enable are written on the cfg channel (index 0 prop gain,
// 1 integral gain, 2 derivative gain, 3 loop enable); only while idle.
// An encoder pulse only steps the position. A target sample holds the input for
// a shift-add multiply followed by a restoring division.
// A control tick with the loop enabled keeps the block busy for the
// proportional product, the integral product and its division by 100, the
// derivative product and its division by 3, the PWM scaling product and the
// PWM division, and a last state that loads the output register, after which
// its result beat is valid. With the loop disabled the beat is loaded while idle.
// One item is worked on at a time. The result sits in an output register, and
// s_axis_tready returns as soon as it is loaded, so the next item may be taken
// while the receiver still stalls; only a new tick waits for the register.
// Reset (aresetn low, synchronous) restores the configuration registers, all loop state and the output valid flag.
module dc_motor_position_pid_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // direction, adc_sample
    input  logic [1:0]  s_axis_tuser,   // mode
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // duty_a, duty_b, gap, bias_on
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);
`include "dc_motor_position_pid_top_macros.svh"

    localparam int AccW = dmp_pkg::AccW;
    localparam int CntW = 6;

    // Configuration registers.
    logic [dmp_pkg::GainW-1:0] prop_gain_reg, integ_gain_reg, deriv_gain_reg;
    logic                      loop_enable_reg;

    // Loop state.
    logic signed [9:0]  position_reg, last_position_reg, target_reg, prior_error_reg;
    logic signed [13:0] integral_acc_reg;
    logic signed [10:0] diff0_reg, diff1_reg, diff2_reg;
    logic [15:0]        stall_count_reg;
    logic               bias_armed_reg;
    logic [12:0]        duty_a_reg, duty_b_reg;

    // Sequencer and serial datapath.
    dmp_pkg::state_t    state_reg, state_next;
    logic [CntW-1:0]    cnt_reg;
    logic [AccW-1:0]    mcand_reg;      // shifted multiplicand (magnitude)
    logic [AccW-1:0]    mplier_reg;     // multiplier, shifted right
    logic [AccW-1:0]    prod_reg;       // product accumulator / dividend
    logic [AccW-1:0]    rem_reg;        // divider remainder
    logic [AccW-1:0]    divisor_reg;
    logic               neg_reg;        // sign of the current term
    logic signed [AccW-1:0] ctrl_reg;   // control word
    logic signed [9:0]  gap_reg;
    logic               out_valid_reg;
    logic [39:0]        out_data_reg;

    logic signed [10:0] gap_raw;
    logic signed [9:0]  gap_w;
    logic               take;
    logic [AccW:0]      rem_shift;
    logic [AccW:0]      rem_sub;

    assign cfg_ready = (state_reg == dmp_pkg::ST_IDLE);
    assign s_axis_tready = (state_reg == dmp_pkg::ST_IDLE) &&
                           !(s_axis_tuser == dmp_pkg::ModeTick && out_valid_reg);
    assign take = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata = out_data_reg;

    always_comb begin
        gap_raw = 11'(target_reg) - 11'(position_reg);
        if (gap_raw > 11'sd240) begin
            gap_raw = gap_raw - 11'sd480;
        end else if (gap_raw < -11'sd240) begin
            gap_raw = gap_raw + 11'sd480;
        end
        gap_w = gap_raw[9:0];
    end

    // One restoring divide step on the remainder and the dividend's top bit.
    assign rem_shift = {rem_reg, prod_reg[AccW-1]};
    assign rem_sub = rem_shift - {1'b0, divisor_reg};

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            dmp_pkg::ST_IDLE: begin
                if (take && s_axis_tuser == dmp_pkg::ModeSample) begin
                    state_next = dmp_pkg::ST_TGT_MUL;
                end else if (take && s_axis_tuser == dmp_pkg::ModeTick &&
                             loop_enable_reg) begin
                    state_next = dmp_pkg::ST_PROP;
                end
            end
            dmp_pkg::ST_TGT_MUL: if (cnt_reg == '0) state_next = dmp_pkg::ST_TGT_DIV;
            dmp_pkg::ST_TGT_DIV: if (cnt_reg == '0) state_next = dmp_pkg::ST_IDLE;
            dmp_pkg::ST_PROP: if (cnt_reg == '0) state_next = dmp_pkg::ST_INTEG;
            dmp_pkg::ST_INTEG: if (cnt_reg == '0) state_next = dmp_pkg::ST_INTEG_DIV;
            dmp_pkg::ST_INTEG_DIV: if (cnt_reg == '0) state_next = dmp_pkg::ST_DERIV;
            dmp_pkg::ST_DERIV: if (cnt_reg == '0) state_next = dmp_pkg::ST_DERIV_DIV;
            dmp_pkg::ST_DERIV_DIV: if (cnt_reg == '0) state_next = dmp_pkg::ST_SCALE;
            dmp_pkg::ST_SCALE: if (cnt_reg == '0) state_next = dmp_pkg::ST_SCALE_DIV;
            dmp_pkg::ST_SCALE_DIV: if (cnt_reg == '0) state_next = dmp_pkg::ST_OUT;
            dmp_pkg::ST_OUT: state_next = dmp_pkg::ST_IDLE;
            default: state_next = dmp_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= dmp_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Finished term: apply the sign to its magnitude.
    function automatic logic signed [AccW-1:0] signed_term(
        input logic [AccW-1:0] mag, input logic neg);
        return neg ? -$signed(mag) : $signed(mag);
    endfunction

    always_ff @(posedge aclk) begin
        logic signed [13:0] iacc;
        logic signed [12:0] dsum;
        logic signed [AccW-1:0] c;
        logic [AccW-1:0] bias;
        logic [15:0] sc;
        logic armed;
        logic signed [AccW-1:0] t;
        iacc = '0; dsum = '0; c = '0; bias = '0; sc = '0; armed = 1'b0; t = '0;
        if (!aresetn) begin
            prop_gain_reg <= 15'd1280;
            integ_gain_reg <= '0;
            deriv_gain_reg <= '0;
            loop_enable_reg <= 1'b1;
            position_reg <= '0;
            last_position_reg <= '0;
            target_reg <= 10'sd120;
            prior_error_reg <= '0;
            integral_acc_reg <= '0;
            diff0_reg <= '0;
            diff1_reg <= '0;
            diff2_reg <= '0;
            stall_count_reg <= '0;
            bias_armed_reg <= 1'b0;
            duty_a_reg <= '0;
            duty_b_reg <= '0;
            out_valid_reg <= 1'b0;
            cnt_reg <= '0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    dmp_pkg::RegPropGain: prop_gain_reg <= cfg_data[14:0];
                    dmp_pkg::RegIntegGain: integ_gain_reg <= cfg_data[14:0];
                    dmp_pkg::RegDerivGain: deriv_gain_reg <= cfg_data[14:0];
                    dmp_pkg::RegLoopEnable: loop_enable_reg <= cfg_data[0];
                    default: ;
                endcase
            end
            if (cnt_reg != '0) cnt_reg <= cnt_reg - 1'b1;
            case (state_reg)
                dmp_pkg::ST_IDLE: begin
                    if (take) begin
                        case (s_axis_tuser)
                            dmp_pkg::ModePulse: begin
                                if (s_axis_tdata[0]) begin
                                    position_reg <= (position_reg == 10'sd239) ?
                                        -10'sd240 : position_reg + 10'sd1;
                                end else begin
                                    position_reg <= (position_reg == -10'sd240) ?
                                        10'sd239 : position_reg - 10'sd1;
                                end
                            end
                            dmp_pkg::ModeSample: begin
                                mcand_reg <= AccW'(s_axis_tdata[10:1]);
                                mplier_reg <= AccW'(479);
                                prod_reg <= '0;
                                neg_reg <= 1'b0;
                                cnt_reg <= 6'd8;
                            end
                            dmp_pkg::ModeTick: begin
                                gap_reg <= gap_w;
                                if (loop_enable_reg) begin
                                    // Update the integral and the differences.
                                    iacc = integral_acc_reg + 14'(gap_w);
                                    if (iacc > 14'sd4800) iacc = 14'sd4800;
                                    else if (iacc < -14'sd4800) iacc = -14'sd4800;
                                    integral_acc_reg <= iacc;
                                    diff2_reg <= diff1_reg;
                                    diff1_reg <= diff0_reg;
                                    diff0_reg <= 11'(gap_w) - 11'(prior_error_reg);
                                    prior_error_reg <= gap_w;
                                    // proportional term: |gap| * prop_gain
                                    mcand_reg <= AccW'(prop_gain_reg);
                                    mplier_reg <= AccW'(gap_w[9] ? -gap_w : gap_w);
                                    neg_reg <= gap_w[9];
                                    prod_reg <= '0;
                                    ctrl_reg <= '0;
                                    cnt_reg <= 6'd9;
                                end else begin
                                    out_data_reg <= {4'd0, bias_armed_reg, gap_w[8:0],
                                                     duty_b_reg, duty_a_reg};
                                    out_valid_reg <= 1'b1;
                                    last_position_reg <= position_reg;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                dmp_pkg::ST_TGT_MUL: begin
                    if (cnt_reg != '0) begin
                        if (mplier_reg[0]) prod_reg <= prod_reg + mcand_reg;
                        mcand_reg <= mcand_reg << 1;
                        mplier_reg <= mplier_reg >> 1;
                    end else begin
                        rem_reg <= '0;
                        divisor_reg <= AccW'(1023);
                        cnt_reg <= 6'd18;
                        // align 19-bit product at the top of the dividend
                        prod_reg <= (mplier_reg[0] ? prod_reg + mcand_reg : prod_reg)
                                    << (AccW - 19);
                    end
                end
                dmp_pkg::ST_PROP, dmp_pkg::ST_INTEG, dmp_pkg::ST_DERIV,
                dmp_pkg::ST_SCALE: begin
                    if (cnt_reg != '0) begin
                        if (mplier_reg[0]) prod_reg <= prod_reg + mcand_reg;
                        mcand_reg <= mcand_reg << 1;
                        mplier_reg <= mplier_reg >> 1;
                    end else begin
                        t = signed_term(mplier_reg[0] ? prod_reg + mcand_reg : prod_reg,
                                        neg_reg);
                        case (state_reg)
                            dmp_pkg::ST_PROP: begin
                                ctrl_reg <= t;
                                mcand_reg <= AccW'(integ_gain_reg);
                                mplier_reg <= AccW'(integral_acc_reg[13] ?
                                    -integral_acc_reg : integral_acc_reg);
                                neg_reg <= integral_acc_reg[13];
                                prod_reg <= '0;
                                cnt_reg <= 6'd12;
                            end
                            dmp_pkg::ST_INTEG, dmp_pkg::ST_DERIV: begin
                                prod_reg <= (mplier_reg[0] ? prod_reg + mcand_reg
                                             : prod_reg) << (AccW - 32);
                                rem_reg <= '0;
                                divisor_reg <= AccW'((state_reg == dmp_pkg::ST_INTEG) ?
                                                     100 : 3);
                                cnt_reg <= 6'd31;
                            end
                            default: begin
                                // ST_SCALE: magnitude * 8000, then / 749568
                                prod_reg <= (mplier_reg[0] ? prod_reg + mcand_reg
                                             : prod_reg);
                                rem_reg <= '0;
                                divisor_reg <= AccW'(2928 * 256);
                                cnt_reg <= 6'(AccW - 1);
                            end
                        endcase
                    end
                end
                dmp_pkg::ST_TGT_DIV, dmp_pkg::ST_INTEG_DIV, dmp_pkg::ST_DERIV_DIV,
                dmp_pkg::ST_SCALE_DIV: begin
                    if (cnt_reg != '0) begin
                        if (!rem_sub[AccW]) begin
                            rem_reg <= rem_sub[AccW-1:0];
                            prod_reg <= {prod_reg[AccW-2:0], 1'b1};
                        end else begin
                            rem_reg <= rem_shift[AccW-1:0];
                            prod_reg <= {prod_reg[AccW-2:0], 1'b0};
                        end
                    end else begin
                        t = signed_term({prod_reg[AccW-2:0], !rem_sub[AccW]}, neg_reg);
                        case (state_reg)
                            dmp_pkg::ST_TGT_DIV: begin
                                target_reg <= 10'(t) - 10'sd240;
                            end
                            dmp_pkg::ST_INTEG_DIV: begin
                                ctrl_reg <= ctrl_reg + t;
                                dsum = 13'(diff0_reg) + 13'(diff1_reg) + 13'(diff2_reg);
                                mcand_reg <= AccW'(deriv_gain_reg) * AccW'(100);
                                mplier_reg <= AccW'(dsum[12] ? -dsum : dsum);
                                neg_reg <= dsum[12];
                                prod_reg <= '0;
                                cnt_reg <= 6'd12;
                            end
                            dmp_pkg::ST_DERIV_DIV: begin
                                c = ctrl_reg + t;
                                sc = stall_count_reg;
                                armed = bias_armed_reg;
                                if (gap_reg > 10'sd24 || gap_reg < -10'sd24) begin
                                    if (position_reg == last_position_reg) begin
                                        sc = stall_count_reg + 16'd1;
                                        if (sc == 16'd5) armed = 1'b1;
                                    end else begin
                                        sc = '0;
                                    end
                                end
                                stall_count_reg <= sc;
                                bias_armed_reg <= armed;
                                last_position_reg <= position_reg;
                                bias = armed ? AccW'(sc) * AccW'(183 * 256) : '0;
                                if (c > 0) begin
                                    c = c + $signed(bias);
                                end else begin
                                    c = c - $signed(bias);
                                end
                                ctrl_reg <= c;
                                neg_reg <= 1'b0;
                                mcand_reg <= AccW'(c[AccW-1] ? -c : c);
                                mplier_reg <= AccW'(dmp_pkg::PwmTop);
                                prod_reg <= '0;
                                cnt_reg <= 6'd12;
                            end
                            default: begin
                                // ST_SCALE_DIV: saturate and set the duties
                                t = signed_term({prod_reg[AccW-2:0], !rem_sub[AccW]},
                                                1'b0);
                                if (t > AccW'(dmp_pkg::PwmTop)) t = AccW'(dmp_pkg::PwmTop);
                                if (gap_reg > 10'sd24 || gap_reg < -10'sd24) begin
                                    if (ctrl_reg > 0) begin
                                        duty_a_reg <= 13'(t);
                                        duty_b_reg <= '0;
                                    end else begin
                                        duty_a_reg <= 13'(dmp_pkg::PwmTop) - 13'(t);
                                        duty_b_reg <= 13'(dmp_pkg::PwmTop);
                                    end
                                end else begin
                                    duty_a_reg <= '0;
                                    duty_b_reg <= '0;
                                end
                            end
                        endcase
                    end
                end
                dmp_pkg::ST_OUT: begin
                    out_data_reg <= {4'd0, bias_armed_reg, gap_reg[8:0],
                                     duty_b_reg, duty_a_reg};
                    out_valid_reg <= 1'b1;
                end
                default: ;
            endcase
        end
    end

    // Tick results only leave from the output register once loaded.
    `DMP_ASSERT_IMP(a_no_take_busy, aclk, aresetn,
        state_reg != dmp_pkg::ST_IDLE, !s_axis_tready)
    `DMP_ASSERT_NEXT(a_out_loaded, aclk, aresetn,
        state_reg == dmp_pkg::ST_OUT, m_axis_tvalid)
    `DMP_ASSERT_IMP(a_duty_range, aclk, aresetn,
        m_axis_tvalid, m_axis_tdata[12:0] <= 13'd8000 && m_axis_tdata[25:13] <= 13'd8000)

endmodule
